### design/tiny_accumulator_cpu_core_unit_macros.svh
// Assertion macros for the tiny accumulator CPU core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TINY_ACCUMULATOR_CPU_CORE_UNIT_MACROS_SVH
`define TINY_ACCUMULATOR_CPU_CORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TACC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TACC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tacc_pkg.sv
// Shared constants and types for the tiny accumulator CPU core.
// No dependencies; used by tacc_ram and the top level.
`default_nettype none
package tacc_pkg;

	localparam int DATA_W    = 8;
	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_HALT  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic [7:0] OP_LDA = 8'h01;
	localparam logic [7:0] OP_LDB = 8'h02;
	localparam logic [7:0] OP_ADD = 8'h03;
	localparam logic [7:0] OP_STA = 8'h04;
	localparam logic [7:0] OP_JMP = 8'h05;
	localparam logic [7:0] OP_HLT = 8'hFF;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_FETCH = 5'b00100,
		S_OPER  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

### design/tacc_ram.sv
// Generic single-port RAM with registered read data.
// Defaults come from tacc_pkg.
`default_nettype none
module tacc_ram #(
	parameter int WIDTH = tacc_pkg::DATA_W,
	parameter int DEPTH = tacc_pkg::MEM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

### design/tiny_accumulator_cpu_core_unit.sv
// Tiny accumulator CPU core: sequencer, registers and shared adder.
// Depends on tacc_pkg, tacc_ram and the assertion macro header.
//
// A command word enters on cmd_valid/cmd_ready with command, mem_address
// and mem_data. Every command word gives exactly one response word on
// rsp_valid/rsp_ready carrying A, B, PC, run state, the read byte and the
// opcode executed. Commands are taken one at a time: cmd_ready is high only
// while the sequencer is idle.
// The sequencer loads the response register in S_DONE, reached from S_IDLE for a
// write, an unused command or a step on a halted core, via S_READ for a read,
// via S_FETCH for a step without operand (ADD, HLT, unknown opcode) and via
// S_FETCH and S_OPER for a step with an operand, then returns to S_IDLE. The
// single-port memory sets this: one access per cycle for fetch, operand, store.
// The PC increment and the ADD share one 8-bit adder.
// A finished response is held in the output register; the core accepts the
// next command while it waits and stalls only when a second response is
// ready before the first has been taken.
// Reset clears A, B, PC and the run state, and marks every memory byte as
// unwritten so that it reads as zero; no clearing pass is needed.
`default_nettype none
`include "tiny_accumulator_cpu_core_unit_macros.svh"
module tiny_accumulator_cpu_core_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  logic [1:0] command,
	input  logic [7:0] mem_address,
	input  logic [7:0] mem_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] acc_a,
	output logic [7:0] reg_b,
	output logic [7:0] prog_counter,
	output logic [1:0] run_state,
	output logic [7:0] read_byte,
	output logic [7:0] last_opcode
);

	tacc_pkg::state_t state_q;
	logic [7:0] a_q, b_q, pc_q, rd_q, op_q;
	logic [1:0] st_q;
	logic [tacc_pkg::MEM_DEPTH-1:0] vld_q;
	logic rvld_q;
	logic rsp_valid_q;
	logic [7:0] acc_a_q, reg_b_q, pc_out_q, read_byte_q, last_opcode_q;
	logic [1:0] run_state_q;

	logic ram_we;
	logic [tacc_pkg::MEM_AW-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata, mem_byte;
	logic [7:0] add_x, add_y, add_sum;
	logic out_load;

	tacc_ram #(
		.WIDTH(tacc_pkg::DATA_W),
		.DEPTH(tacc_pkg::MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Bytes never written since reset read as zero.
	assign mem_byte = rvld_q ? ram_rdata : 8'h00;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pc_q;
		ram_wdata = mem_data;
		case (state_q)
			tacc_pkg::S_IDLE: begin
				if (command != tacc_pkg::CMD_STEP) begin
					ram_addr = mem_address;
				end
				ram_we = cmd_valid && (command == tacc_pkg::CMD_WRITE);
			end
			tacc_pkg::S_OPER: begin
				ram_addr  = mem_byte;
				ram_wdata = a_q;
				ram_we    = (op_q == tacc_pkg::OP_STA);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		add_x = pc_q;
		add_y = 8'd1;
		if ((state_q == tacc_pkg::S_FETCH) && (mem_byte == tacc_pkg::OP_ADD)) begin
			add_x = a_q;
			add_y = b_q;
		end
	end
	assign add_sum = add_x + add_y;

	assign out_load  = (state_q == tacc_pkg::S_DONE) && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = (state_q == tacc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tacc_pkg::S_IDLE;
			a_q         <= 8'h00;
			b_q         <= 8'h00;
			pc_q        <= 8'h00;
			st_q        <= tacc_pkg::ST_RUN;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[ram_addr];
			if (ram_we) begin
				vld_q[ram_addr] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				tacc_pkg::S_IDLE: begin
					if (cmd_valid) begin
						case (command)
							tacc_pkg::CMD_READ: state_q <= tacc_pkg::S_READ;
							tacc_pkg::CMD_STEP: begin
								if (st_q == tacc_pkg::ST_RUN) begin
									pc_q    <= add_sum;
									state_q <= tacc_pkg::S_FETCH;
								end else begin
									state_q <= tacc_pkg::S_DONE;
								end
							end
							default: state_q <= tacc_pkg::S_DONE;
						endcase
					end
				end
				tacc_pkg::S_READ: state_q <= tacc_pkg::S_DONE;
				tacc_pkg::S_FETCH: begin
					case (mem_byte)
						tacc_pkg::OP_LDA, tacc_pkg::OP_LDB,
						tacc_pkg::OP_STA, tacc_pkg::OP_JMP: begin
							pc_q    <= add_sum;
							state_q <= tacc_pkg::S_OPER;
						end
						tacc_pkg::OP_ADD: begin
							a_q     <= add_sum;
							state_q <= tacc_pkg::S_DONE;
						end
						tacc_pkg::OP_HLT: begin
							st_q    <= tacc_pkg::ST_HALT;
							state_q <= tacc_pkg::S_DONE;
						end
						default: begin
							st_q    <= tacc_pkg::ST_FAULT;
							state_q <= tacc_pkg::S_DONE;
						end
					endcase
				end
				tacc_pkg::S_OPER: begin
					case (op_q)
						tacc_pkg::OP_LDA: a_q  <= mem_byte;
						tacc_pkg::OP_LDB: b_q  <= mem_byte;
						tacc_pkg::OP_JMP: pc_q <= mem_byte;
						default: begin
						end
					endcase
					state_q <= tacc_pkg::S_DONE;
				end
				tacc_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= tacc_pkg::S_IDLE;
					end
				end
				default: state_q <= tacc_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == tacc_pkg::S_IDLE) && cmd_valid) begin
			rd_q <= 8'h00;
			op_q <= 8'h00;
		end
		if (state_q == tacc_pkg::S_READ) begin
			rd_q <= mem_byte;
		end
		if (state_q == tacc_pkg::S_FETCH) begin
			op_q <= mem_byte;
		end
		if (out_load) begin
			acc_a_q       <= a_q;
			reg_b_q       <= b_q;
			pc_out_q      <= pc_q;
			run_state_q   <= st_q;
			read_byte_q   <= rd_q;
			last_opcode_q <= op_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign acc_a        = acc_a_q;
	assign reg_b        = reg_b_q;
	assign prog_counter = pc_out_q;
	assign run_state    = run_state_q;
	assign read_byte    = read_byte_q;
	assign last_opcode  = last_opcode_q;

	`TACC_ASSERT_IMP(a_fetch_running, state_q == tacc_pkg::S_FETCH, st_q == tacc_pkg::ST_RUN, "Opcode fetch on a halted core.")
	`TACC_ASSERT_IMP(a_write_slot, ram_we, (state_q == tacc_pkg::S_IDLE) || (state_q == tacc_pkg::S_OPER), "Memory write outside a write slot.")
	`TACC_ASSERT_NXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready, "Command taken while another is in progress.")
	`TACC_ASSERT_NXT(a_halt_sticky, st_q != tacc_pkg::ST_RUN, st_q == $past(st_q), "Halted core changed its run state.")

endmodule
`default_nettype wire
